/* sv/assert_macros.svh */
// assertion macros used by the checker file
// needs a clk and a rst signal in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define CHK_ALWAYS(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("check failed: name");

// consequent holds in the cycle after the trigger, outside reset
`define CHK_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("check failed: name");

// same, also checked across reset
`define CHK_NEXT_RST(name, trig, cons) \
  name: assert property (@(posedge clk) (trig) |=> (cons)) \
    else $error("check failed: name");

`endif

/* sv/alpm_pkg.sv */
// types and constants of the acceleration limited planar mover
// no dependencies
package alpm_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 1'b1;

  localparam logic [17:0] RATE_RESET  = 18'd3277;
  localparam logic [19:0] ACCEL_RESET = 20'd13107;
  localparam logic [17:0] RATE_FLOOR  = 18'd328;
  localparam logic [19:0] ACCEL_FLOOR = 20'd656;
  localparam logic [32:0] SNAP_DIST   = 33'd7;

  // iteration counts of the serial units
  localparam int unsigned DIV_QW = 22;
  localparam logic [5:0] MUL_STEPS  = 6'd8;
  localparam logic [5:0] ROOT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'(DIV_QW);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_HYP_A,
    ST_HYP_B,
    ST_HYP_ROOT,
    ST_ADT,
    ST_DECIDE,
    ST_MUL_2AD,
    ST_ROOT_VW,
    ST_MUL_WX,
    ST_DIV_WX,
    ST_MUL_WY,
    ST_DIV_WY,
    ST_ERR,
    ST_CHECK,
    ST_MUL_CX,
    ST_DIV_CX,
    ST_MUL_CY,
    ST_DIV_CY,
    ST_VEL,
    ST_POS_X,
    ST_POS_Y,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    UNIT_NONE,
    UNIT_MUL,
    UNIT_ROOT,
    UNIT_DIV
  } unit_t;

  typedef enum logic [1:0] {
    HP_DIST,
    HP_SPEED,
    HP_ERR
  } hphase_t;

endpackage

/* sv/accel_limited_planar_mover_unit.sv */
// Planar mover: each item carries a goal and a time step; the block moves its kept position
// and velocity toward the goal under speed and acceleration limits and returns one result
// item. One item is worked at a time through a sequencer that drives three shared serial
// units: a 4-bit-digit multiplier, a square root giving one root bit per cycle and a
// restoring divider giving one quotient bit per cycle. The input stalls until the result is
// registered and the next item can be taken in the cycle after that, while a finished result
// may still wait at the output register. Depends on alpm_pkg.
module accel_limited_planar_mover_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [alpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  goal_x,
  input  logic signed [31:0]                  goal_y,
  input  logic [15:0]                         step_time,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  pos_x_out,
  output logic signed [31:0]                  pos_y_out,
  output logic signed [31:0]                  vel_x_out,
  output logic signed [31:0]                  vel_y_out,
  output logic                                arrived
);

  alpm_pkg::state_t  state, state_next;
  alpm_pkg::unit_t   unit;
  alpm_pkg::hphase_t hphase;

  // configuration and kept state
  logic [17:0] max_rate;
  logic [19:0] max_accel;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;

  // sequencer control
  logic       launched;
  logic [5:0] cnt;
  logic [5:0] unit_steps;
  logic       unit_done;
  logic       in_accept, commit;

  // item registers
  logic signed [31:0] gx, gy;
  logic [15:0] dt;
  logic [17:0] rate;
  logic [19:0] accel;
  logic        dx_neg, dy_neg;
  logic [31:0] mag_dx, mag_dy;
  logic [31:0] hu, hv;
  logic [32:0] dist_len, speed, err;
  logic [19:0] adt;
  logic [17:0] vw;
  logic signed [22:0] wx, wy;
  logic [33:0] ex_x, ex_y;
  logic [31:0] nvx, nvy, npx, npy;
  logic        snap;

  // serial units
  logic [63:0] ma, acc;
  logic [31:0] mb;
  logic [63:0] sx;
  logic [34:0] srem;
  logic [31:0] sroot;
  logic [34:0] drem;
  logic [alpm_pkg::DIV_QW-1:0] dnum, dq;
  logic [32:0] dden;

  // operand selection
  logic [63:0] op_a;
  logic [31:0] op_b;
  logic [32:0] op_den;

  logic        hyp_shift;
  logic [31:0] hyp_u, hyp_v;
  logic [32:0] hyp_res;
  logic [32:0] diff_x, diff_y;
  logic [33:0] ex_calc_x, ex_calc_y;
  logic [34:0] sq_shift, sq_trial;
  logic [34:0] dv_t;
  logic        snap_cond;
  logic [22:0] q_ext;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [31:0] mag34(input logic [33:0] v);
    logic [33:0] n;
    n = -v;
    return v[33] ? n[31:0] : v[31:0];
  endfunction

  function automatic logic [31:0] sat35(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // pos + floor(vel * dt / 2^16), prod is |vel| * dt
  function automatic logic [31:0] pos_advance(input logic [31:0] p, input logic neg,
                                              input logic [47:0] prod);
    logic [48:0] rnd;
    logic [32:0] up;
    logic signed [34:0] delta;
    logic signed [34:0] sum;
    rnd   = {1'b0, prod} + 49'd65535;
    up    = neg ? rnd[48:16] : {1'b0, prod[47:16]};
    delta = neg ? -$signed({2'b00, up}) : $signed({2'b00, up});
    sum   = $signed({{3{p[31]}}, p}) + delta;
    return sat35(sum);
  endfunction

  assign in_stall  = (state != alpm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign commit    = (state == alpm_pkg::ST_DONE) && (!out_valid || !out_stall);
  assign unit_done = launched && (cnt == 6'd0);

  assign diff_x    = {goal_x[31], goal_x} - {pos_x[31], pos_x};
  assign diff_y    = {goal_y[31], goal_y} - {pos_y[31], pos_y};
  assign hyp_shift = hu[31] | hv[31];
  assign hyp_u     = hyp_shift ? {1'b0, hu[31:1]} : hu;
  assign hyp_v     = hyp_shift ? {1'b0, hv[31:1]} : hv;
  assign hyp_res   = hyp_shift ? {sroot, 1'b0} : {1'b0, sroot};
  assign ex_calc_x = {{11{wx[22]}}, wx} - {{2{vel_x[31]}}, vel_x};
  assign ex_calc_y = {{11{wy[22]}}, wy} - {{2{vel_y[31]}}, vel_y};
  assign sq_shift  = {srem[32:0], sx[63:62]};
  assign sq_trial  = {1'b0, sroot, 2'b01};
  assign dv_t      = {drem[33:0], dnum[alpm_pkg::DIV_QW-1]};
  assign snap_cond = (dist_len < alpm_pkg::SNAP_DIST) && (speed < {12'b0, adt, 1'b0});
  assign q_ext     = {1'b0, dq};

  // next state, unit selection and operands
  always_comb begin
    state_next = state;
    unit       = alpm_pkg::UNIT_NONE;
    op_a       = '0;
    op_b       = '0;
    op_den     = dist_len;
    unique case (state)
      alpm_pkg::ST_IDLE: begin
        if (in_valid) state_next = alpm_pkg::ST_HYP_A;
      end
      alpm_pkg::ST_HYP_A: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, hyp_u};
        op_b = hyp_u;
        if (unit_done) state_next = alpm_pkg::ST_HYP_B;
      end
      alpm_pkg::ST_HYP_B: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, hyp_v};
        op_b = hyp_v;
        if (unit_done) state_next = alpm_pkg::ST_HYP_ROOT;
      end
      alpm_pkg::ST_HYP_ROOT: begin
        unit = alpm_pkg::UNIT_ROOT;
        if (unit_done) begin
          unique case (hphase)
            alpm_pkg::HP_DIST:  state_next = alpm_pkg::ST_HYP_A;
            alpm_pkg::HP_SPEED: state_next = alpm_pkg::ST_ADT;
            alpm_pkg::HP_ERR:   state_next = alpm_pkg::ST_CHECK;
            default:            state_next = alpm_pkg::ST_IDLE;
          endcase
        end
      end
      alpm_pkg::ST_ADT: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {44'b0, accel};
        op_b = {16'b0, dt};
        if (unit_done) state_next = alpm_pkg::ST_DECIDE;
      end
      alpm_pkg::ST_DECIDE: begin
        if (snap_cond) state_next = alpm_pkg::ST_DONE;
        else if (dist_len == 33'd0) state_next = alpm_pkg::ST_ERR;
        else state_next = alpm_pkg::ST_MUL_2AD;
      end
      alpm_pkg::ST_MUL_2AD: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {31'b0, dist_len};
        op_b = {11'b0, accel, 1'b0};
        if (unit_done) state_next = alpm_pkg::ST_ROOT_VW;
      end
      alpm_pkg::ST_ROOT_VW: begin
        unit = alpm_pkg::UNIT_ROOT;
        if (unit_done) state_next = alpm_pkg::ST_MUL_WX;
      end
      alpm_pkg::ST_MUL_WX: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag_dx};
        op_b = {14'b0, vw};
        if (unit_done) state_next = alpm_pkg::ST_DIV_WX;
      end
      alpm_pkg::ST_DIV_WX: begin
        unit = alpm_pkg::UNIT_DIV;
        if (unit_done) state_next = alpm_pkg::ST_MUL_WY;
      end
      alpm_pkg::ST_MUL_WY: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag_dy};
        op_b = {14'b0, vw};
        if (unit_done) state_next = alpm_pkg::ST_DIV_WY;
      end
      alpm_pkg::ST_DIV_WY: begin
        unit = alpm_pkg::UNIT_DIV;
        if (unit_done) state_next = alpm_pkg::ST_ERR;
      end
      alpm_pkg::ST_ERR: begin
        state_next = alpm_pkg::ST_HYP_A;
      end
      alpm_pkg::ST_CHECK: begin
        if (err > {13'b0, adt}) state_next = alpm_pkg::ST_MUL_CX;
        else state_next = alpm_pkg::ST_VEL;
      end
      alpm_pkg::ST_MUL_CX: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag34(ex_x)};
        op_b = {12'b0, adt};
        if (unit_done) state_next = alpm_pkg::ST_DIV_CX;
      end
      alpm_pkg::ST_DIV_CX: begin
        unit   = alpm_pkg::UNIT_DIV;
        op_den = err;
        if (unit_done) state_next = alpm_pkg::ST_MUL_CY;
      end
      alpm_pkg::ST_MUL_CY: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag34(ex_y)};
        op_b = {12'b0, adt};
        if (unit_done) state_next = alpm_pkg::ST_DIV_CY;
      end
      alpm_pkg::ST_DIV_CY: begin
        unit   = alpm_pkg::UNIT_DIV;
        op_den = err;
        if (unit_done) state_next = alpm_pkg::ST_VEL;
      end
      alpm_pkg::ST_VEL: begin
        state_next = alpm_pkg::ST_POS_X;
      end
      alpm_pkg::ST_POS_X: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag33({nvx[31], nvx})};
        op_b = {16'b0, dt};
        if (unit_done) state_next = alpm_pkg::ST_POS_Y;
      end
      alpm_pkg::ST_POS_Y: begin
        unit = alpm_pkg::UNIT_MUL;
        op_a = {32'b0, mag33({nvy[31], nvy})};
        op_b = {16'b0, dt};
        if (unit_done) state_next = alpm_pkg::ST_DONE;
      end
      alpm_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = alpm_pkg::ST_IDLE;
      end
      default: state_next = alpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    unique case (unit)
      alpm_pkg::UNIT_MUL:  unit_steps = alpm_pkg::MUL_STEPS;
      alpm_pkg::UNIT_ROOT: unit_steps = alpm_pkg::ROOT_STEPS;
      alpm_pkg::UNIT_DIV:  unit_steps = alpm_pkg::DIV_STEPS;
      default:             unit_steps = 6'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control, configuration and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      launched  <= 1'b0;
      cnt       <= 6'd0;
      out_valid <= 1'b0;
      max_rate  <= alpm_pkg::RATE_RESET;
      max_accel <= alpm_pkg::ACCEL_RESET;
      pos_x     <= '0;
      pos_y     <= '0;
      vel_x     <= '0;
      vel_y     <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          alpm_pkg::CFG_MAX_RATE:  max_rate  <= cfg_data[17:0];
          alpm_pkg::CFG_MAX_ACCEL: max_accel <= cfg_data;
          default: ;
        endcase
      end
      if (unit != alpm_pkg::UNIT_NONE) begin
        if (!launched) begin
          launched <= 1'b1;
          cnt      <= unit_steps;
        end else if (cnt != 6'd0) begin
          cnt <= cnt - 6'd1;
        end else begin
          launched <= 1'b0;
        end
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (commit) begin
        out_valid <= 1'b1;
        if (snap) begin
          pos_x <= gx;
          pos_y <= gy;
          vel_x <= '0;
          vel_y <= '0;
        end else begin
          pos_x <= npx;
          pos_y <= npy;
          vel_x <= nvx;
          vel_y <= nvy;
        end
      end
    end
  end

  // datapath and serial units
  always_ff @(posedge clk) begin
    if (in_accept) begin
      gx     <= goal_x;
      gy     <= goal_y;
      dt     <= step_time;
      rate   <= (max_rate < alpm_pkg::RATE_FLOOR) ? alpm_pkg::RATE_FLOOR : max_rate;
      accel  <= (max_accel < alpm_pkg::ACCEL_FLOOR) ? alpm_pkg::ACCEL_FLOOR : max_accel;
      dx_neg <= diff_x[32];
      dy_neg <= diff_y[32];
      mag_dx <= mag33(diff_x);
      mag_dy <= mag33(diff_y);
      hu     <= mag33(diff_x);
      hv     <= mag33(diff_y);
      hphase <= alpm_pkg::HP_DIST;
      snap   <= 1'b0;
    end

    case (unit)
      alpm_pkg::UNIT_MUL: begin
        if (!launched) begin
          ma <= op_a;
          mb <= op_b;
          // second square adds onto the first
          if (state != alpm_pkg::ST_HYP_B) acc <= '0;
        end else if (cnt != 6'd0) begin
          acc <= acc + ma * {60'b0, mb[3:0]};
          ma  <= {ma[59:0], 4'b0};
          mb  <= {4'b0, mb[31:4]};
        end
      end
      alpm_pkg::UNIT_ROOT: begin
        if (!launched) begin
          sx    <= acc;
          srem  <= '0;
          sroot <= '0;
        end else if (cnt != 6'd0) begin
          sx <= {sx[61:0], 2'b00};
          if (sq_shift >= sq_trial) begin
            srem  <= sq_shift - sq_trial;
            sroot <= {sroot[30:0], 1'b1};
          end else begin
            srem  <= sq_shift;
            sroot <= {sroot[30:0], 1'b0};
          end
        end
      end
      alpm_pkg::UNIT_DIV: begin
        if (!launched) begin
          // numerator is below den * 2^22, so its high part starts below den
          drem <= acc[alpm_pkg::DIV_QW+34:alpm_pkg::DIV_QW];
          dnum <= acc[alpm_pkg::DIV_QW-1:0];
          dq   <= '0;
          dden <= op_den;
        end else if (cnt != 6'd0) begin
          dnum <= {dnum[alpm_pkg::DIV_QW-2:0], 1'b0};
          if (dv_t >= {2'b00, dden}) begin
            drem <= dv_t - {2'b00, dden};
            dq   <= {dq[alpm_pkg::DIV_QW-2:0], 1'b1};
          end else begin
            drem <= dv_t;
            dq   <= {dq[alpm_pkg::DIV_QW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase

    if (unit_done) begin
      case (state)
        alpm_pkg::ST_HYP_ROOT: begin
          case (hphase)
            alpm_pkg::HP_DIST: begin
              dist_len <= hyp_res;
              hu       <= mag33({vel_x[31], vel_x});
              hv       <= mag33({vel_y[31], vel_y});
              hphase   <= alpm_pkg::HP_SPEED;
            end
            alpm_pkg::HP_SPEED: speed <= hyp_res;
            default:            err   <= hyp_res;
          endcase
        end
        alpm_pkg::ST_ADT:     adt <= acc[35:16];
        alpm_pkg::ST_ROOT_VW: vw  <= (sroot > {14'b0, rate}) ? rate : sroot[17:0];
        alpm_pkg::ST_DIV_WX:  wx  <= dx_neg ? -$signed(q_ext) : $signed(q_ext);
        alpm_pkg::ST_DIV_WY:  wy  <= dy_neg ? -$signed(q_ext) : $signed(q_ext);
        alpm_pkg::ST_DIV_CX:  ex_x <= ex_x[33] ? -{12'b0, dq} : {12'b0, dq};
        alpm_pkg::ST_DIV_CY:  ex_y <= ex_y[33] ? -{12'b0, dq} : {12'b0, dq};
        alpm_pkg::ST_POS_X:   npx <= pos_advance(pos_x, nvx[31], acc[47:0]);
        alpm_pkg::ST_POS_Y:   npy <= pos_advance(pos_y, nvy[31], acc[47:0]);
        default: ;
      endcase
    end

    case (state)
      alpm_pkg::ST_DECIDE: begin
        snap <= snap_cond;
        wx   <= '0;
        wy   <= '0;
      end
      alpm_pkg::ST_ERR: begin
        ex_x   <= ex_calc_x;
        ex_y   <= ex_calc_y;
        hu     <= mag34(ex_calc_x);
        hv     <= mag34(ex_calc_y);
        hphase <= alpm_pkg::HP_ERR;
      end
      alpm_pkg::ST_VEL: begin
        nvx <= sat35($signed({ex_x[33], ex_x}) + $signed({{3{vel_x[31]}}, vel_x}));
        nvy <= sat35($signed({ex_y[33], ex_y}) + $signed({{3{vel_y[31]}}, vel_y}));
      end
      default: ;
    endcase

    if (commit) begin
      arrived <= snap;
      if (snap) begin
        pos_x_out <= gx;
        pos_y_out <= gy;
        vel_x_out <= '0;
        vel_y_out <= '0;
      end else begin
        pos_x_out <= npx;
        pos_y_out <= npy;
        vel_x_out <= nvx;
        vel_y_out <= nvy;
      end
    end
  end

endmodule

/* sv/alpm_checker.sv */
// port level checks of the planar mover, bound to the top level
// depends on assert_macros.svh and accel_limited_planar_mover_unit
`include "assert_macros.svh"

module alpm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pos_x_out,
  input logic signed [31:0] vel_x_out,
  input logic signed [31:0] vel_y_out,
  input logic               arrived
);

  // a held result keeps its pos_x_out and arrived fields
  `CHK_NEXT(held_result_stable, out_valid && out_stall,
            out_valid && $stable(pos_x_out) && $stable(arrived))

  // an arrival always comes with zero velocity
  `CHK_ALWAYS(arrived_zero_vel, !(out_valid && arrived) || (vel_x_out == 0 && vel_y_out == 0))

  // after an item is taken the block is busy
  `CHK_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)

  // reset empties the output and clears the input stall
  `CHK_NEXT_RST(reset_clears_out, rst, !out_valid && !in_stall)

endmodule

bind accel_limited_planar_mover_unit alpm_checker u_alpm_checker (.*);

/* verif/tb_accel_limited_planar_mover_unit.sv */
// testbench for accel_limited_planar_mover_unit: drives goal items, predicts each result
// item from a behavioral mover model and checks it field by field; depends on alpm_pkg
module tb_accel_limited_planar_mover_unit;

  typedef struct {
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [15:0]        dt;
  } goal_item_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               arr;
  } motion_t;

  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [alpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [alpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] goal_x = '0;
  logic signed [31:0] goal_y = '0;
  logic [15:0] step_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x_out, pos_y_out, vel_x_out, vel_y_out;
  logic arrived;

  goal_item_t pend_q[$];
  motion_t    motion_q[$];

  // mover state and limits as predicted
  longint mv_px, mv_py, mv_vx, mv_vy;
  longint unsigned lim_rate, lim_accel;

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_arrived = 0;
  int cycles = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;

  accel_limited_planar_mover_unit u_dut (.*);

  always #6 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // length of (u,v), prescaled so the squares fit
  function automatic longint unsigned hyp_len(longint unsigned u, longint unsigned v);
    int s;
    longint unsigned a, b;
    s = 0;
    while ((u >> s) >= 64'h8000_0000 || (v >> s) >= 64'h8000_0000) s++;
    a = u >> s;
    b = v >> s;
    return root64(a * a + b * b) << s;
  endfunction

  // num * m / den truncated toward zero
  function automatic longint scaled_quot(longint num, longint unsigned m,
                                          longint unsigned den);
    longint unsigned q;
    q = mag64(num) * m / den;
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic advance_mover(goal_item_t it);
    longint gx, gy, dx, dy, wx, wy, ex, ey;
    longint unsigned rate, acc, d, spd, adt, vw, e;
    motion_t m;
    gx = it.gx;
    gy = it.gy;
    rate = lim_rate < 328 ? 328 : lim_rate;
    acc = lim_accel < 656 ? 656 : lim_accel;
    dx = gx - mv_px;
    dy = gy - mv_py;
    d = hyp_len(mag64(dx), mag64(dy));
    spd = hyp_len(mag64(mv_vx), mag64(mv_vy));
    adt = (acc * it.dt) >> 16;
    m.arr = 1'b0;
    if (d < 7 && spd < 2 * adt) begin
      mv_px = gx;
      mv_py = gy;
      mv_vx = 0;
      mv_vy = 0;
      m.arr = 1'b1;
    end else begin
      wx = 0;
      wy = 0;
      if (d > 0) begin
        vw = root64(2 * acc * d);
        if (vw > rate) vw = rate;
        wx = scaled_quot(dx, vw, d);
        wy = scaled_quot(dy, vw, d);
      end
      ex = wx - mv_vx;
      ey = wy - mv_vy;
      e = hyp_len(mag64(ex), mag64(ey));
      // clip the velocity change to the acceleration budget
      if (e > adt) begin
        ex = scaled_quot(ex, adt, e);
        ey = scaled_quot(ey, adt, e);
      end
      mv_vx = sat32(mv_vx + ex);
      mv_vy = sat32(mv_vy + ey);
      mv_px = sat32(mv_px + ((mv_vx * longint'(it.dt)) >>> 16));
      mv_py = sat32(mv_py + ((mv_vy * longint'(it.dt)) >>> 16));
    end
    m.px = mv_px[31:0];
    m.py = mv_py[31:0];
    m.vx = mv_vx[31:0];
    m.vy = mv_vy[31:0];
    motion_q.push_back(m);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("error: result %0d %s got %h expected %h", n_checked, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    goal_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.gx = goal_x;
        it.gy = goal_y;
        it.dt = step_time;
        advance_mover(it);
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pend_q.pop_front();
          in_valid <= 1'b1;
          goal_x <= it.gx;
          goal_y <= it.gy;
          step_time <= it.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    motion_t m;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (motion_q.size() == 0) begin
          report("unexpected item pos_x_out", pos_x_out, 32'h0);
        end else begin
          m = motion_q.pop_front();
          if (pos_x_out !== m.px) report("pos_x_out", pos_x_out, m.px);
          if (pos_y_out !== m.py) report("pos_y_out", pos_y_out, m.py);
          if (vel_x_out !== m.vx) report("vel_x_out", vel_x_out, m.vx);
          if (vel_y_out !== m.vy) report("vel_y_out", vel_y_out, m.vy);
          if (arrived !== m.arr) report("arrived", {31'b0, arrived}, {31'b0, m.arr});
          if (m.arr) n_arrived++;
          n_checked++;
        end
      end
      out_stall <= (hold_cnt != 0) || ($urandom_range(99) < recv_idle);
    end
  end

  // long output hold so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_go && !hold_done) begin
      hold_cnt <= 2500;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("accel_limited_planar_mover_unit: mismatch");
      $finish;
    end
  end

  task automatic set_limit(logic [alpm_pkg::CFG_IDX_W-1:0] idx,
                           logic [alpm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == alpm_pkg::CFG_MAX_RATE) lim_rate = val[17:0];
    else lim_accel = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_goal(logic signed [31:0] gx, logic signed [31:0] gy, logic [15:0] dt);
    goal_item_t it;
    it.gx = gx;
    it.gy = gy;
    it.dt = dt;
    pend_q.push_back(it);
  endtask

  task automatic wait_sent;
    while (pend_q.size() != 0 || in_valid) @(posedge clk);
  endtask

  task automatic wait_drained;
    wait_sent();
    while (motion_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // goal sequences near the current position, with some noise items between them
  task automatic run_moves(int n);
    int k, len;
    longint bx, by;
    logic [15:0] dt;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) == 0) begin
        add_goal(32'($urandom), 32'($urandom), 16'($urandom));
        k++;
      end else begin
        wait_sent();
        bx = mv_px + $urandom_range(8000) - 4000;
        by = mv_py + $urandom_range(8000) - 4000;
        len = $urandom_range(30, 4);
        repeat (len) begin
          dt = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(65535, 2000));
          add_goal(32'(sat32(bx)), 32'(sat32(by)), dt);
        end
        k += len;
      end
    end
  endtask

  initial begin
    lim_rate = alpm_pkg::RATE_RESET;
    lim_accel = alpm_pkg::ACCEL_RESET;
    mv_px = 0;
    mv_py = 0;
    mv_vx = 0;
    mv_vy = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle = 22;
    recv_idle = 45;
    // directed: at the goal, zero time step, far extremes, tiny and full steps
    add_goal(0, 0, 16'hFFFF);
    add_goal(0, 0, 16'h0000);
    add_goal(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1);
    add_goal(32'sh7FFF_FFFF, 32'sh8000_0000, 16'hFFFF);
    add_goal(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF);
    add_goal(32'sh8000_0000, 32'sh7FFF_FFFF, 16'h0000);
    add_goal(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000);
    add_goal(0, 0, 16'h5555);
    add_goal(0, 0, 16'hAAAA);
    add_goal(3, -2, 16'hFFFF);
    add_goal(3, -2, 16'hFFFF);
    add_goal(3, -2, 16'hFFFF);
    add_goal(3, -2, 16'd1);
    wait_drained();
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'd0);
    set_limit(alpm_pkg::CFG_MAX_ACCEL, 20'd0);
    run_moves(120);
    wait_drained();

    send_idle = 45;
    recv_idle = 22;
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'd131072);
    set_limit(alpm_pkg::CFG_MAX_ACCEL, 20'd655360);
    hold_go = 1'b1;
    run_moves(150);
    wait_drained();
    // upper data bits beyond the rate register width are dropped
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'hFFFFF);
    set_limit(alpm_pkg::CFG_MAX_ACCEL, 20'hFFFFF);
    run_moves(140);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'd328);
    set_limit(alpm_pkg::CFG_MAX_ACCEL, 20'd656);
    run_moves(140);
    wait_drained();
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'($urandom_range(131072, 328)));
    set_limit(alpm_pkg::CFG_MAX_ACCEL, 20'($urandom_range(655360, 656)));
    run_moves(140);
    wait_drained();
    set_limit(alpm_pkg::CFG_MAX_RATE, 20'(alpm_pkg::RATE_RESET));
    set_limit(alpm_pkg::CFG_MAX_ACCEL, alpm_pkg::ACCEL_RESET);
    run_moves(140);
    wait_drained();

    $display("covered %0d goal items over seven limit settings, %0d results checked",
             n_items, n_checked);
    $display("%0d steps snapped onto their goal", n_arrived);
    if (errors == 0 && motion_q.size() == 0) begin
      $display("accel_limited_planar_mover_unit: match");
    end else begin
      $display("accel_limited_planar_mover_unit: mismatch");
    end
    $finish;
  end

endmodule

/* accel_limited_planar_mover_unit.f */
+incdir+sv
sv/alpm_pkg.sv
sv/accel_limited_planar_mover_unit.sv
sv/alpm_checker.sv
verif/tb_accel_limited_planar_mover_unit.sv
